### sv/trix_pkg.sv
// ----------------------------------------------------------------------------
// trix_pkg: shared types and constants for the triple EWMA rate-of-change block
// Holds the payload structs, the kind codes, the controller state type, the
// command and status bundles, and the fixed constants of the result path.
// ----------------------------------------------------------------------------
`default_nettype none

package trix_pkg;

  // Smoothing weight register.
  localparam int unsigned ALPHA_W = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd13107;

  // Sample kind codes.
  localparam logic [1:0] KIND_SEED   = 2'd0;
  localparam logic [1:0] KIND_TRIAL  = 2'd1;
  localparam logic [1:0] KIND_COMMIT = 2'd2;

  // Result path: percent scale and the clipping limits of a 32-bit result.
  localparam logic [31:0] PCT     = 32'd100;
  localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] LIM_NEG = 32'h8000_0000;

  // Quotient bits computed by the divider. Any quotient of 2^QBITS or more
  // is already past the clipping point, so only the low QBITS bits matter.
  localparam int unsigned QBITS = 25;
  localparam logic [QBITS-1:0] QLIM = QBITS'(LIM_POS / PCT);
  localparam int unsigned CNT_W = $clog2(QBITS);

  // Input and output transactions.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [31:0] trix_value;
    logic               zero_base;
    logic               saturated;
  } out_t;

  // Which of the three averages the shared multiplier works on.
  typedef enum logic [1:0] {
    STG_FIRST,
    STG_SECOND,
    STG_THIRD
  } stage_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;
    logic   mul;
    logic   add;
    stage_t stage;
    logic   div_init;
    logic   div_step;
    logic   finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_seed;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### sv/trix_ctrl.sv
// ----------------------------------------------------------------------------
// trix_ctrl: sequencer for the triple EWMA rate-of-change block
// Steps the datapath through three multiply/add pairs, the divider setup,
// the serial division and the final result and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module trix_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  trix_pkg::status_t status,
  output trix_pkg::cmd_t    cmd
);

  trix_pkg::state_t state, state_next;
  trix_pkg::stage_t stage, stage_next;
  logic [trix_pkg::CNT_W-1:0] cnt, cnt_next;

  // State, stage and division counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trix_pkg::ST_IDLE;
      stage <= trix_pkg::STG_FIRST;
      cnt   <= '0;
    end else begin
      state <= state_next;
      stage <= stage_next;
      cnt   <= cnt_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    stage_next = stage;
    cnt_next   = cnt;
    case (state)
      trix_pkg::ST_IDLE: begin
        if (in_valid) begin
          stage_next = trix_pkg::STG_FIRST;
          state_next = status.in_seed ? trix_pkg::ST_FINISH : trix_pkg::ST_MUL;
        end
      end
      trix_pkg::ST_MUL: begin
        state_next = trix_pkg::ST_ADD;
      end
      trix_pkg::ST_ADD: begin
        case (stage)
          trix_pkg::STG_FIRST: begin
            stage_next = trix_pkg::STG_SECOND;
            state_next = trix_pkg::ST_MUL;
          end
          trix_pkg::STG_SECOND: begin
            stage_next = trix_pkg::STG_THIRD;
            state_next = trix_pkg::ST_MUL;
          end
          default: begin
            state_next = trix_pkg::ST_DIV_INIT;
          end
        endcase
      end
      trix_pkg::ST_DIV_INIT: begin
        cnt_next   = trix_pkg::CNT_W'(trix_pkg::QBITS - 1);
        state_next = trix_pkg::ST_DIV_STEP;
      end
      trix_pkg::ST_DIV_STEP: begin
        if (cnt == '0) begin
          state_next = trix_pkg::ST_FINISH;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      trix_pkg::ST_FINISH: begin
        if (status.out_free) begin
          state_next = trix_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = trix_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd          = '0;
    cmd.stage    = stage;
    in_stall     = 1'b1;
    case (state)
      trix_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      trix_pkg::ST_MUL:      cmd.mul      = 1'b1;
      trix_pkg::ST_ADD:      cmd.add      = 1'b1;
      trix_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      trix_pkg::ST_DIV_STEP: cmd.div_step = 1'b1;
      trix_pkg::ST_FINISH:   cmd.finish   = status.out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // The division always runs its full count before the result step.
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == trix_pkg::ST_FINISH) && $past(state == trix_pkg::ST_DIV_STEP)
      |-> $past(cnt == '0))
    else $error("division left before its last step");

endmodule

`default_nettype wire

### sv/trix_dp.sv
// ----------------------------------------------------------------------------
// trix_dp: datapath for the triple EWMA rate-of-change block
// Holds the stored averages, the weight register, one shared multiplier,
// a restoring divider one quotient bit a cycle, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trix_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  trix_pkg::cmd_t                     cmd,
  output trix_pkg::status_t                  status,
  input  trix_pkg::in_t                      in_data,
  input  wire                                cfg_write,
  input  wire [trix_pkg::ALPHA_W-1:0]        cfg_data,
  input  wire                                out_stall,
  output logic                               out_valid,
  output trix_pkg::out_t                     out_data
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = DW + trix_pkg::ALPHA_W + 2;   // product width
  localparam int SW = PW + 1;                       // average sum width
  localparam int NW = DW + 1 + FRAC_BITS;           // dividend width
  localparam int XW = 65;                           // sample clamp width
  localparam int QB = trix_pkg::QBITS;

  localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;
  localparam logic signed [XW-1:0] XMAX = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [XW-1:0] XMIN = ~XMAX;

  // Registers.
  logic [trix_pkg::ALPHA_W-1:0] alpha;
  logic signed [DW-1:0] avg1, avg2, avg3;
  logic signed [DW-1:0] e1, e2, e3;
  logic signed [DW-1:0] x;
  logic [1:0]           kind;
  logic signed [PW-1:0] prod;
  logic [DW-1:0]        bmag;
  logic                 neg;
  logic                 ovf;
  logic [DW:0]          rem;
  logic [QB-1:0]        lowbits;
  logic [QB-1:0]        quo;

  // Combinational signals.
  logic signed [XW-1:0] xs;
  logic signed [DW-1:0] x_in;
  logic signed [DW-1:0] mul_in, mul_last;
  logic signed [DW:0]   d;
  logic signed [trix_pkg::ALPHA_W:0] alpha_s;
  logic signed [PW-1:0] step;
  logic signed [SW-1:0] sum;
  logic signed [DW-1:0] ewma;
  logic signed [DW:0]   diff;
  logic [DW:0]          dmag;
  logic [NW-1:0]        num;
  logic [DW:0]          trial;
  logic                 qbit;
  logic [31:0]          lim;
  logic [31:0]          m_raw;
  logic [31:0]          m;
  logic                 sat;
  logic                 base_zero;
  trix_pkg::out_t       result;

  assign status.in_seed  = (in_data.kind == trix_pkg::KIND_SEED);
  assign status.out_free = !out_valid || !out_stall;

  // Sample clamped to the average width.
  always_comb begin
    xs = XW'($signed(in_data.sample));
    if (xs > XMAX) begin
      x_in = DW'(XMAX);
    end else if (xs < XMIN) begin
      x_in = DW'(XMIN);
    end else begin
      x_in = DW'(xs);
    end
  end

  // Operand selection for the shared multiplier and adder.
  always_comb begin
    case (cmd.stage)
      trix_pkg::STG_FIRST: begin
        mul_in   = x;
        mul_last = avg1;
      end
      trix_pkg::STG_SECOND: begin
        mul_in   = e1;
        mul_last = avg2;
      end
      trix_pkg::STG_THIRD: begin
        mul_in   = e2;
        mul_last = avg3;
      end
      default: begin
        mul_in   = x;
        mul_last = avg1;
      end
    endcase
  end

  // New average: last plus the floored weighted step, clipped to the width.
  always_comb begin
    d       = (DW+1)'(mul_in) - (DW+1)'(mul_last);
    alpha_s = $signed({1'b0, alpha});
    step    = prod >>> FRAC_BITS;
    sum     = SW'(mul_last) + SW'(step);
    if (sum > SMAX) begin
      ewma = DW'(SMAX);
    end else if (sum < SMIN) begin
      ewma = DW'(SMIN);
    end else begin
      ewma = DW'(sum);
    end
  end

  // Divider operands and one restoring step.
  always_comb begin
    diff  = (DW+1)'(e3) - (DW+1)'(avg3);
    dmag  = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);
    num   = NW'(dmag) << FRAC_BITS;
    trial = {rem[DW-1:0], lowbits[QB-1]};
    qbit  = (trial >= (DW+1)'(bmag));
  end

  // Final result from the quotient.
  always_comb begin
    base_zero = (avg3 == '0);
    lim       = neg ? trix_pkg::LIM_NEG : trix_pkg::LIM_POS;
    m_raw     = 32'(quo) * trix_pkg::PCT;
    sat       = 1'b0;
    m         = m_raw;
    if (ovf || (quo > trix_pkg::QLIM) || (m_raw > lim)) begin
      m   = lim;
      sat = 1'b1;
    end
    result = '0;
    if (kind != trix_pkg::KIND_SEED) begin
      if (base_zero) begin
        result.zero_base = 1'b1;
      end else begin
        result.trix_value = neg ? $signed(32'(-m)) : $signed(m);
        result.saturated  = sat;
      end
    end
  end

  // Weight register.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= trix_pkg::ALPHA_RESET;
    end else if (cfg_write) begin
      alpha <= cfg_data;
    end
  end

  // Stored averages, updated by a seed or a commit at the result step.
  always_ff @(posedge clk) begin
    if (rst) begin
      avg1 <= '0;
      avg2 <= '0;
      avg3 <= '0;
    end else if (cmd.finish) begin
      if (kind == trix_pkg::KIND_SEED) begin
        avg1 <= x;
        avg2 <= x;
        avg3 <= x;
      end else if (kind == trix_pkg::KIND_COMMIT) begin
        avg1 <= e1;
        avg2 <= e2;
        avg3 <= e3;
      end
    end
  end

  // Working registers: capture, multiply, add and divide.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= x_in;
      kind <= in_data.kind;
    end
    if (cmd.mul) begin
      prod <= PW'(alpha_s) * PW'(d);
    end
    if (cmd.add) begin
      case (cmd.stage)
        trix_pkg::STG_FIRST:  e1 <= ewma;
        trix_pkg::STG_SECOND: e2 <= ewma;
        default:              e3 <= ewma;
      endcase
    end
    if (cmd.div_init) begin
      bmag    <= avg3[DW-1] ? DW'(-avg3) : DW'(avg3);
      neg     <= diff[DW] ^ avg3[DW-1];
      ovf     <= (num >> QB) >= NW'(avg3[DW-1] ? DW'(-avg3) : DW'(avg3));
      rem     <= (DW+1)'(num >> QB);
      lowbits <= num[QB-1:0];
    end else if (cmd.div_step) begin
      rem     <= qbit ? (trial - (DW+1)'(bmag)) : trial;
      lowbits <= {lowbits[QB-2:0], 1'b0};
      quo     <= {quo[QB-2:0], qbit};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= result;
    end
  end

  // The stored averages only move at a result step.
  a_avg_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(cmd.finish) |-> $stable(avg3) && $stable(avg1))
    else $error("stored averages changed outside a result step");

  // A zero base forces a zero, unclipped result.
  a_zero_base: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_base |-> (out_data.trix_value == '0) && !out_data.saturated)
    else $error("zero base with nonzero result");

  // A clipped result sits at one of the two limits.
  a_sat_lim: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      (out_data.trix_value == $signed(trix_pkg::LIM_POS)) ||
      (out_data.trix_value == $signed(trix_pkg::LIM_NEG)))
    else $error("clipped result not at a limit");

endmodule

`default_nettype wire

### sv/triple_ewma_rate_of_change.sv
// ----------------------------------------------------------------------------
// triple_ewma_rate_of_change: TRIX rate of change of a triple EWMA
// Cascades three exponential averages of a Q16.16 sample and gives the
// percent change of the third one, with seed, trial and commit kinds.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                       Direction  Transaction
//   input     in_valid, in_stall, in_data   in         valid & !stall
//   output    out_valid, out_stall, out_data out       valid & !stall
//   config    cfg_write, cfg_data           in         cfg_write
//
// An update holds the block from the accepting cycle through three
// multiply/add pairs, one divider setup, 25 divider steps and one result step,
// with its result registered at the result step. A seed skips to that step.
// The result step waits while an earlier result is stalled at the output.
// Reset is synchronous: averages clear to zero and the weight to 13107.
// ----------------------------------------------------------------------------
`default_nettype none

module triple_ewma_rate_of_change #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  trix_pkg::in_t                in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output trix_pkg::out_t               out_data,
  input  wire                          cfg_write,
  input  wire [trix_pkg::ALPHA_W-1:0]  cfg_data
);

  trix_pkg::cmd_t    cmd;
  trix_pkg::status_t status;

  // Sequencer.
  trix_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  trix_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/sv/triple_ewma_rate_of_change_tb.sv
// ----------------------------------------------------------------------------
// triple_ewma_rate_of_change_tb: self-checking testbench for the TRIX block
// Drives seed, trial and commit samples through the block under several
// smoothing weights and idling patterns. A behavioral copy of the triple
// average and percent-change arithmetic predicts every result, which is then
// compared field by field with what the block returns.
// ----------------------------------------------------------------------------

module triple_ewma_rate_of_change_tb;

  // The fourth kind code has no name in the package; the block treats it as
  // a trial update.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int     FRAC           = 16;
  localparam longint S32_MAX        = 64'sd2147483647;
  localparam longint S32_MIN        = -S32_MAX - 1;
  localparam int     N_DIRECTED     = 23;
  localparam int     N_PHASES       = 6;
  localparam int     ITEMS_PER_PHASE = 315;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     DRAIN_CYCLES   = 40;
  localparam int     CYCLE_LIMIT    = 1_000_000;

  // One row of the directed table. When known is set, result is the expected
  // output; otherwise the predictor supplies it.
  typedef struct {
    logic [trix_pkg::ALPHA_W-1:0] alpha;
    trix_pkg::in_t                item;
    logic                         known;
    trix_pkg::out_t               result;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  trix_pkg::in_t                in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  trix_pkg::out_t               out_data;
  logic                         cfg_write = 1'b0;
  logic [trix_pkg::ALPHA_W-1:0] cfg_data = trix_pkg::ALPHA_RESET;

  // Predictor state: weight and the three stored averages.
  logic [trix_pkg::ALPHA_W-1:0] alpha_model = trix_pkg::ALPHA_RESET;
  longint             avg_first = 0;
  longint             avg_second = 0;
  longint             avg_third = 0;

  // Results still owed by the block, oldest first.
  trix_pkg::out_t     expected_trix [$];

  // Idling controls and the receiver hold-off request.
  int                 src_idle_pct = 0;
  int                 sink_stall_pct = 0;
  int                 hold_id = 0;
  int                 hold_served = 0;
  int                 hold_left = 0;

  // Run statistics.
  int                 err_count = 0;
  int                 sent_count = 0;
  int                 checked_count = 0;
  int                 zero_base_count = 0;
  int                 saturated_count = 0;
  int                 alpha_writes = 0;
  int                 cycles_run = 0;

  // Random walk of the price inside a seeded sequence.
  longint             walk_price = 0;
  logic               walk_open = 1'b0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // Fresh averages are zero, so trial and commit both report a zero base.
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_TRIAL, 32'sh0005_0000}, 1'b1,
      '{32'sh0, 1'b1, 1'b0}},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_COMMIT, 32'sh0005_0000}, 1'b1,
      '{32'sh0, 1'b1, 1'b0}},
    // Seeds at the sample extremes, each followed by a move the other way.
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_SEED, 32'sh7FFF_FFFF}, 1'b1,
      '{32'sh0, 1'b0, 1'b0}},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_COMMIT, 32'sh8000_0000}, 1'b0, '0},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_SEED, 32'sh8000_0000}, 1'b1,
      '{32'sh0, 1'b0, 1'b0}},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_TRIAL, 32'sh7FFF_FFFF}, 1'b0, '0},
    // A tiny base with a huge move clips positive, and negative for base -1.
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_SEED, 32'sh0000_0001}, 1'b1,
      '{32'sh0, 1'b0, 1'b0}},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_TRIAL, 32'sh7FFF_FFFF}, 1'b1,
      '{32'sh7FFF_FFFF, 1'b0, 1'b1}},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_SEED, 32'shFFFF_FFFF}, 1'b1,
      '{32'sh0, 1'b0, 1'b0}},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_TRIAL, 32'sh7FFF_FFFF}, 1'b1,
      '{32'sh8000_0000, 1'b0, 1'b1}},
    // Spare kind must not store; the two commits after it must.
    '{trix_pkg::ALPHA_RESET, '{KIND_SPARE, 32'sh0001_0000}, 1'b0, '0},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_COMMIT, 32'sh0001_0000}, 1'b0, '0},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_COMMIT, 32'sh0001_0000}, 1'b0, '0},
    // A flat price gives no change.
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_SEED, 32'sh0064_0000}, 1'b1,
      '{32'sh0, 1'b0, 1'b0}},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_COMMIT, 32'sh0064_0000}, 1'b1,
      '{32'sh0, 1'b0, 1'b0}},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_TRIAL, 32'sh0000_0000}, 1'b0, '0},
    // Zero weight freezes the averages; unit weight tracks the sample.
    '{17'd0, '{trix_pkg::KIND_COMMIT, 32'sh1234_5678}, 1'b1,
      '{32'sh0, 1'b0, 1'b0}},
    '{17'd65536, '{trix_pkg::KIND_COMMIT, 32'sh00C8_0000}, 1'b1,
      '{32'sh0064_0000, 1'b0, 1'b0}},
    // Weight above one overshoots and clips the averages.
    '{17'h1FFFF, '{trix_pkg::KIND_TRIAL, 32'sh8000_0000}, 1'b0, '0},
    '{17'h1FFFF, '{trix_pkg::KIND_COMMIT, 32'sh7FFF_FFFF}, 1'b0, '0},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_TRIAL, 32'shFFFF_0000}, 1'b0, '0},
    // Seeding zero makes the next commit see a zero base.
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_SEED, 32'sh0000_0000}, 1'b1,
      '{32'sh0, 1'b0, 1'b0}},
    '{trix_pkg::ALPHA_RESET, '{trix_pkg::KIND_COMMIT, 32'sh0001_0000}, 1'b1,
      '{32'sh0, 1'b1, 1'b0}}
  };

  triple_ewma_rate_of_change dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clip a wide value to the signed 32-bit range.
  function automatic longint clip32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // One exponential average step; the weighted move is floored.
  function automatic longint ewma_update(longint last, longint x);
    longint          diff;
    longint unsigned mag;
    longint unsigned prod;
    diff = x - last;
    mag  = (diff < 0) ? -diff : diff;
    prod = mag * alpha_model;
    if (diff < 0)
      return clip32(last - longint'((prod + (64'd1 << FRAC) - 64'd1) >> FRAC));
    return clip32(last + longint'(prod >> FRAC));
  endfunction

  // Expected result of one sample; updates the stored averages on a commit.
  function automatic trix_pkg::out_t predict_trix(trix_pkg::in_t item);
    longint          x;
    longint          e1;
    longint          e2;
    longint          e3;
    longint          diff;
    longint unsigned dmag;
    longint unsigned bmag;
    longint unsigned quot;
    longint unsigned lim;
    longint unsigned mag;
    logic            neg;
    trix_pkg::out_t  res;
    res = '0;
    x   = longint'($signed(item.sample));
    if (item.kind == trix_pkg::KIND_SEED) begin
      avg_first  = x;
      avg_second = x;
      avg_third  = x;
      return res;
    end
    e1 = ewma_update(avg_first, x);
    e2 = ewma_update(avg_second, e1);
    e3 = ewma_update(avg_third, e2);
    if (avg_third == 0) begin
      res.zero_base = 1'b1;
    end else begin
      diff = e3 - avg_third;
      dmag = (diff < 0) ? -diff : diff;
      bmag = (avg_third < 0) ? -avg_third : avg_third;
      neg  = (diff < 0) != (avg_third < 0);
      quot = (dmag << FRAC) / bmag;
      lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (quot > lim / 64'd100) begin
        mag = lim;
        res.saturated = 1'b1;
      end else begin
        mag = quot * 64'd100;
        if (mag > lim) begin
          mag = lim;
          res.saturated = 1'b1;
        end
      end
      res.trix_value = neg ? 32'(-mag) : 32'(mag);
    end
    if (item.kind == trix_pkg::KIND_COMMIT) begin
      avg_first  = e1;
      avg_second = e2;
      avg_third  = e3;
    end
    return res;
  endfunction

  // Offer one sample, wait for the transaction, and queue its expected result.
  // Called at a rising edge; returns at the edge of acceptance with valid high.
  task automatic send_sample(trix_pkg::in_t item, logic known, trix_pkg::out_t result);
    trix_pkg::out_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted = predict_trix(item);
    expected_trix.push_back(known ? result : predicted);
    sent_count++;
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_trix.size() != 0) @(posedge clk);
  endtask

  // Write the smoothing weight; only called while the block is idle.
  task automatic write_alpha(logic [trix_pkg::ALPHA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    alpha_model = value;
    alpha_writes++;
  endtask

  // Mostly seeded random walks of the price, with some raw noise mixed in.
  task automatic run_random(int count);
    trix_pkg::in_t item;
    int  r;
    int  k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        item.kind   = 2'($urandom_range(0, 3));
        item.sample = $urandom;
      end else if (r < 12 || !walk_open) begin
        // Start a new sequence at a price of random scale.
        case ($urandom_range(0, 7))
          0: walk_price = 0;
          1: walk_price = longint'($signed($urandom));
          2: walk_price = longint'($urandom_range(0, 511)) - 256;
          default: begin
            walk_price = longint'($urandom_range(1, 32'h7FFF_FFFF));
            if ($urandom_range(0, 1) == 1) walk_price = -walk_price;
          end
        endcase
        walk_open   = 1'b1;
        item.kind   = trix_pkg::KIND_SEED;
        item.sample = 32'(walk_price);
      end else begin
        walk_price = clip32(walk_price +
                            (longint'($signed($urandom)) >>> $urandom_range(3, 30)));
        k = $urandom_range(0, 19);
        if (k < 14)      item.kind = trix_pkg::KIND_COMMIT;
        else if (k < 19) item.kind = trix_pkg::KIND_TRIAL;
        else             item.kind = KIND_SPARE;
        item.sample = 32'(walk_price);
      end
      send_sample(item, 1'b0, '0);
    end
  endtask

  // Compare one returned result with the oldest expectation.
  task automatic check_result(trix_pkg::out_t got);
    trix_pkg::out_t want;
    if (expected_trix.size() == 0) begin
      $error("Unexpected result transaction: trix_value %0d", got.trix_value);
      err_count++;
    end else begin
      want = expected_trix.pop_front();
      checked_count++;
      if (got.zero_base) zero_base_count++;
      if (got.saturated) saturated_count++;
      if (got.trix_value !== want.trix_value) begin
        $error("trix_value: expected %0d, actual %0d", want.trix_value, got.trix_value);
        err_count++;
      end
      if (got.zero_base !== want.zero_base) begin
        $error("zero_base: expected %0b, actual %0b", want.zero_base, got.zero_base);
        err_count++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
        err_count++;
      end
    end
  endtask

  // Receiver: check each result transaction and decide the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result(out_data);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_id != hold_served) begin
      hold_served <= hold_id;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $error("Timed out after %0d cycles", cycles_run);
    $display("Some tests failed");
    $finish;
  end

  // Sender and sequencing of the test phases.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table; the weight changes only once the block has drained.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].alpha != alpha_model) begin
        wait_idle();
        write_alpha(directed_rows[i].alpha);
      end
      send_sample(directed_rows[i].item, directed_rows[i].known, directed_rows[i].result);
    end

    // Random phases, each with its own weight and idling pattern.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_alpha(17'($urandom_range(1, 65536)));
          src_idle_pct = 0;
          sink_stall_pct <= 0;
        end
        1: begin
          write_alpha(17'd65536);
          src_idle_pct = 83;
          sink_stall_pct <= 0;
        end
        2: begin
          write_alpha(17'($urandom_range(65537, 131071)));
          src_idle_pct = 0;
          sink_stall_pct <= 83;
        end
        3: begin
          write_alpha(17'($urandom_range(100, 2000)));
          src_idle_pct = 12;
          sink_stall_pct <= 12;
        end
        4: begin
          write_alpha(17'($urandom_range(0, 131071)));
          src_idle_pct = 40;
          sink_stall_pct <= 40;
        end
        default: begin
          // The receiver holds off for a long stretch while samples keep coming.
          write_alpha(trix_pkg::ALPHA_RESET);
          src_idle_pct = 0;
          sink_stall_pct <= 0;
          hold_id <= hold_id + 1;
        end
      endcase
      run_random(ITEMS_PER_PHASE);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples under %0d weight settings in %0d cycles.",
             sent_count, alpha_writes, cycles_run);
    $display("Checked %0d results: %0d with zero base, %0d clipped, %0d errors.",
             checked_count, zero_base_count, saturated_count, err_count);
    if (err_count == 0 && expected_trix.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
